// ----- design/avsm_pkg.sv -----
// ----------------------------------------------------------------------------
// avsm_pkg
// Shared types and constants for the averaging voice sample mixer.
// ----------------------------------------------------------------------------
package avsm_pkg;

  localparam int VOICES            = 9;
  localparam int SAMPLES_PER_VOICE = 4096;
  localparam int SAMPLE_BITS       = 16;

  localparam int MIN_DIVISOR = 1;

  localparam int VI_W        = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W       = $clog2(VOICES + 1);
  localparam int POS_W       = $clog2(SAMPLES_PER_VOICE + 1);
  localparam int STORE_DEPTH = VOICES * SAMPLES_PER_VOICE;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SUM_W       = SAMPLE_BITS + ((VOICES > 1) ? $clog2(VOICES) : 0);
  localparam int DBIT_W      = $clog2(SUM_W + 1);

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_START  = 3'd1,
    MODE_STOP   = 3'd2,
    MODE_SAMPLE = 3'd3,
    MODE_LENGTH = 3'd4
  } avsm_mode_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  voice;
    logic [11:0] address;
    logic [15:0] value;
  } avsm_req_t;

  typedef struct packed {
    logic [15:0] mixed_sample;
    logic [3:0]  voices_mixed;
  } avsm_res_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } avsm_div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } avsm_div_rsp_t;

endpackage

// ----- design/avsm_sample_ram.sv -----
// ----------------------------------------------------------------------------
// avsm_sample_ram
// Sample store for all voices: one write port, one registered read port.
// ----------------------------------------------------------------------------
module avsm_sample_ram import avsm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [STORE_AW-1:0]    waddr_i,
  input  logic [SAMPLE_BITS-1:0] wdata_i,
  input  logic                   re_i,
  input  logic [STORE_AW-1:0]    raddr_i,
  output logic [SAMPLE_BITS-1:0] rdata_o
);

  logic [SAMPLE_BITS-1:0] mem_q [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/avsm_divider.sv -----
// ----------------------------------------------------------------------------
// avsm_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module avsm_divider import avsm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  avsm_div_req_t req_i,
  output avsm_div_rsp_t rsp_o
);

  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W:0]    rem_q, rem_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic [DBIT_W-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [CNT_W:0]    shifted;
  logic [CNT_W+1:0]  trial;

  always_comb begin
    shifted = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, div_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      quo_d = req_i.dividend;
      rem_d = '0;
      div_d = req_i.divisor;
      cnt_d = DBIT_W'(SUM_W);
    end else if (cnt_q != '0) begin
      if (!trial[CNT_W+1]) begin
        rem_d = trial[CNT_W:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - DBIT_W'(1);
      done_d = (cnt_q == DBIT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- design/averaging_voice_sample_mixer_core.sv -----
// ----------------------------------------------------------------------------
// averaging_voice_sample_mixer_core
// Nine-voice sample mixer: voice state, sample store, scan sequencer and
// averaging divider.
// ----------------------------------------------------------------------------
//   channel   signals                      direction
//   request   in_valid_i  in_stall_o  in_req_i     in
//   result    out_valid_o out_stall_i out_res_o    out
//
// Loads, start and stop are applied in idle without leaving it. A tick scans
// every voice in turn (at most one store read per voice), then passes
// through a drain state, the serial divider and an output state.
// Reset clears voice flags, positions and lengths; the sample store is not
// cleared. One result waits in the output register while new requests are
// taken; a tick cannot finish until that register is free.
// ----------------------------------------------------------------------------
module averaging_voice_sample_mixer_core import avsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  avsm_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output avsm_res_t out_res_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_DIV   = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [VI_W-1:0]   idx_q, idx_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  avsm_res_t         res_q, res_d;

  logic              active_q [VOICES];
  logic [POS_W-1:0]  pos_q    [VOICES];
  logic [POS_W-1:0]  len_q    [VOICES];

  logic                   accept;
  logic                   voice_ok;
  logic [VI_W-1:0]        vsel;
  logic                   cur_act;
  logic [POS_W-1:0]       cur_pos;
  logic                   cur_done;
  logic                   rd_en;
  logic                   wr_en;
  logic [STORE_AW-1:0]    raddr;
  logic [STORE_AW-1:0]    waddr;
  logic [SAMPLE_BITS-1:0] rdata;
  logic [POS_W-1:0]       new_len;
  logic                   out_free;
  avsm_div_req_t          div_req;
  avsm_div_rsp_t          div_rsp;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign voice_ok    = ({1'b0, in_req_i.voice} < 5'(VOICES));
  assign vsel        = in_req_i.voice[VI_W-1:0];
  assign out_free    = !out_valid_q || !out_stall_i;

  assign cur_act  = active_q[idx_q];
  assign cur_pos  = pos_q[idx_q];
  assign cur_done = (cur_pos >= len_q[idx_q]);
  assign rd_en    = (state_q == S_SCAN) && cur_act && !cur_done;
  assign raddr    = STORE_AW'(idx_q) * STORE_AW'(SAMPLES_PER_VOICE) + STORE_AW'(cur_pos);

  assign wr_en = accept && (in_req_i.mode == MODE_SAMPLE) && voice_ok &&
                 ({5'b0, in_req_i.address} < 17'(SAMPLES_PER_VOICE));
  assign waddr = STORE_AW'(vsel) * STORE_AW'(SAMPLES_PER_VOICE) +
                 STORE_AW'(in_req_i.address);

  assign new_len = ({1'b0, in_req_i.value} > 17'(SAMPLES_PER_VOICE)) ?
                   POS_W'(SAMPLES_PER_VOICE) : POS_W'(in_req_i.value);

  avsm_sample_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (in_req_i.value[SAMPLE_BITS-1:0]),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign div_req.start    = (state_q == S_DRAIN);
  assign div_req.dividend = sum_d;
  assign div_req.divisor  = (count_q != '0) ? count_q : CNT_W'(MIN_DIVISOR);

  avsm_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    count_d     = count_q;
    pend_d      = rd_en;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    if (pend_q) begin
      sum_d = sum_q + SUM_W'(rdata);
    end
    case (state_q)
      S_IDLE: begin
        if (accept && (in_req_i.mode == MODE_TICK)) begin
          state_d = S_SCAN;
          idx_d   = '0;
          sum_d   = '0;
          count_d = '0;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          count_d = count_q + CNT_W'(1);
        end
        if (idx_q == VI_W'(VOICES - 1)) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + VI_W'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          res_d.mixed_sample = 16'(div_rsp.quotient);
          res_d.voices_mixed = 4'(count_q);
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    res_q <= res_d;
  end

  // voice state: requests in idle, retire or advance during the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        active_q[i] <= 1'b0;
        pos_q[i]    <= '0;
        len_q[i]    <= '0;
      end
    end else if (state_q == S_SCAN) begin
      if (cur_act) begin
        if (cur_done) begin
          active_q[idx_q] <= 1'b0;
          pos_q[idx_q]    <= '0;
        end else begin
          pos_q[idx_q] <= cur_pos + POS_W'(1);
        end
      end
    end else if (accept && voice_ok) begin
      case (in_req_i.mode)
        MODE_START:  active_q[vsel] <= 1'b1;
        MODE_STOP:   active_q[vsel] <= 1'b0;
        MODE_LENGTH: len_q[vsel]    <= new_len;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide phase");

  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SCAN || state_q == S_DRAIN))
    else $error("store read returned outside the scan");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(VOICES))
    else $error("contributing voice count out of range");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished tick did not reach the output register");

endmodule
